// File: hdl/yaw_pitch_direction_vector_top_macros.svh
`ifndef YAW_PITCH_DIRECTION_VECTOR_TOP_MACROS_SVH
`define YAW_PITCH_DIRECTION_VECTOR_TOP_MACROS_SVH

// Both macros expect clk and rst_n in the scope where they are used.

`define YPDV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ypdv check failed");

`define YPDV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ypdv check failed");

`endif

// File: hdl/ypdv_pkg.sv
`default_nettype none

package ypdv_pkg;

  localparam int DELTA_W    = 16;
  localparam int SENS_W     = 16;
  localparam int DIR_W      = 16;
  localparam int YAW_W      = 25;
  localparam int PITCH_W    = 24;
  localparam int CS_W       = 32;
  localparam int ANG_W      = 26;
  localparam int ATAN_W     = 22;
  localparam int CNT_W      = 5;
  localparam int WRAP_STEPS = 8;
  localparam int PROD_STEPS = CS_W;
  localparam int TABLE_LEN  = 24;

  localparam int CORDIC_STEPS_DEF = 16;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic        [SENS_W-1:0]  sens_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic        [YAW_W-1:0]   yaw_t;
  typedef logic signed [PITCH_W-1:0] pitch_t;

  localparam sens_t  SENS_RESET  = 16'd6554;
  localparam yaw_t   YAW_RESET   = 25'd17694720;
  localparam yaw_t   FULL_TURN   = 25'd23592960;
  localparam pitch_t PITCH_LIMIT = 24'sd5832704;

  localparam logic signed [ANG_W-1:0] FULL_S    = 26'sd23592960;
  localparam logic signed [ANG_W-1:0] HALF_S    = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] QUARTER_S = 26'sd5898240;

  localparam logic [34:0] WRAP_BIAS = 35'd3019898880;
  localparam logic [31:0] MOD_TOP   = 32'd3019898880;

  localparam logic signed [CS_W-1:0] GAIN_Q30 = 32'sh26DD3B6A;

  function automatic logic [ATAN_W-1:0] atan_deg(input logic [CNT_W-1:0] i);
    logic [ATAN_W-1:0] a;
    unique case (i)
      5'd0:    a = 22'd2949120;
      5'd1:    a = 22'd1740967;
      5'd2:    a = 22'd919879;
      5'd3:    a = 22'd466945;
      5'd4:    a = 22'd234379;
      5'd5:    a = 22'd117304;
      5'd6:    a = 22'd58666;
      5'd7:    a = 22'd29335;
      5'd8:    a = 22'd14668;
      5'd9:    a = 22'd7334;
      5'd10:   a = 22'd3667;
      5'd11:   a = 22'd1833;
      5'd12:   a = 22'd917;
      5'd13:   a = 22'd458;
      5'd14:   a = 22'd229;
      5'd15:   a = 22'd115;
      5'd16:   a = 22'd57;
      5'd17:   a = 22'd29;
      5'd18:   a = 22'd14;
      5'd19:   a = 22'd7;
      5'd20:   a = 22'd4;
      5'd21:   a = 22'd2;
      5'd22:   a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ypdv_ifs.sv
`default_nettype none

interface ypdv_in_if;
  logic             valid;
  logic             ready;
  ypdv_pkg::delta_t delta_x;
  ypdv_pkg::delta_t delta_y;

  modport source (output valid, output delta_x, output delta_y, input ready);
  modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

interface ypdv_cfg_if;
  logic            valid;
  logic            ready;
  ypdv_pkg::sens_t sensitivity;

  modport source (output valid, output sensitivity, input ready);
  modport sink   (input valid, input sensitivity, output ready);
endinterface

interface ypdv_out_if;
  logic             valid;
  logic             ready;
  ypdv_pkg::dir_t   dir_x;
  ypdv_pkg::dir_t   dir_y;
  ypdv_pkg::dir_t   dir_z;
  ypdv_pkg::yaw_t   yaw_angle;
  ypdv_pkg::pitch_t pitch_angle;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output yaw_angle, output pitch_angle, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                  input yaw_angle, input pitch_angle, output ready);
endinterface

`default_nettype wire

// File: hdl/yaw_pitch_direction_vector_top.sv
// Requests are handled one at a time: in_if.ready is high only in idle, so a new request is
// taken only after the previous one has finished the bit-serial sensitivity multiply, the
// 8-step yaw wrap, the CORDIC iterations and the bit-serial direction product. A result may
// wait in the output register meanwhile; the product's last step holds until that register is free.
// Reset (rst_n low, synchronous): sensitivity 6554, yaw 270 degrees, pitch 0, no result held.
`default_nettype none

module yaw_pitch_direction_vector_top #(
  parameter int CORDIC_STEPS = ypdv_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ypdv_in_if.sink    in_if,
  ypdv_cfg_if.sink   cfg_if,
  ypdv_out_if.source out_if
);

  localparam int CW = ypdv_pkg::CNT_W;
  localparam int SW = ypdv_pkg::CS_W;
  localparam int AW = ypdv_pkg::ANG_W;

  localparam int ROT_STEPS = (CORDIC_STEPS < ypdv_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                                  : ypdv_pkg::TABLE_LEN;

  localparam logic [CW-1:0] MUL_LAST  = CW'(ypdv_pkg::SENS_W - 1);
  localparam logic [CW-1:0] WRAP_LAST = CW'(ypdv_pkg::WRAP_STEPS - 1);
  localparam logic [CW-1:0] ROT_LAST  = CW'(ROT_STEPS - 1);
  localparam logic [CW-1:0] PROD_LAST = CW'(ypdv_pkg::PROD_STEPS - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_WRAP = 7'b0001000,
    ST_FOLD = 7'b0010000,
    ST_ROT  = 7'b0100000,
    ST_PROD = 7'b1000000
  } state_t;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [AW-1:0] z;
  } rot_t;

  function automatic rot_t rot_step(input rot_t v, input logic [CW-1:0] i);
    rot_t                 r;
    logic signed [SW-1:0] xv;
    logic signed [SW-1:0] yv;
    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] ys;
    logic signed [AW-1:0] zv;
    logic signed [AW-1:0] a;
    xv = v.x;
    yv = v.y;
    zv = v.z;
    xs = xv >>> i;
    ys = yv >>> i;
    a  = $signed({{(AW - ypdv_pkg::ATAN_W){1'b0}}, ypdv_pkg::atan_deg(i)});
    if (!zv[AW-1]) begin
      r.x = xv - ys;
      r.y = yv + xs;
      r.z = zv - a;
    end else begin
      r.x = xv + ys;
      r.y = yv - xs;
      r.z = zv + a;
    end
    return r;
  endfunction

  function automatic ypdv_pkg::dir_t sat_q15(input logic signed [19:0] v);
    ypdv_pkg::dir_t r;
    if (v > 20'sd32767) begin
      r = 16'sd32767;
    end else if (v < -20'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  ypdv_pkg::sens_t       sens_r, sens_nxt;
  ypdv_pkg::yaw_t        yaw_acc_r, yaw_acc_nxt;
  ypdv_pkg::pitch_t      pitch_acc_r, pitch_acc_nxt;
  logic signed [SW-1:0]  mx_r, mx_nxt;
  logic signed [SW-1:0]  my_r, my_nxt;
  ypdv_pkg::sens_t       sh_r, sh_nxt;
  logic signed [SW-1:0]  px_r, px_nxt;
  logic signed [SW-1:0]  py_r, py_nxt;
  logic [32:0]           u_r, u_nxt;
  logic [31:0]           mod_r, mod_nxt;
  logic                  flip_r, flip_nxt;
  rot_t                  ca_r, ca_nxt;
  rot_t                  cb_r, cb_nxt;
  logic signed [SW-1:0]  mc_r, mc_nxt;
  logic signed [SW-1:0]  ms_r, ms_nxt;
  logic [2*SW-1:0]       pc_r, pc_nxt;
  logic [2*SW-1:0]       ps_r, ps_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ypdv_pkg::dir_t        dir_x_r, dir_x_nxt;
  ypdv_pkg::dir_t        dir_y_r, dir_y_nxt;
  ypdv_pkg::dir_t        dir_z_r, dir_z_nxt;
  ypdv_pkg::yaw_t        yaw_o_r, yaw_o_nxt;
  ypdv_pkg::pitch_t      pitch_o_r, pitch_o_nxt;

  logic signed [32:0]    pitch_sum;
  logic [32:0]           u_step;
  logic signed [AW-1:0]  fold_a;
  logic                  fold_flip;
  rot_t                  rot_a;
  rot_t                  rot_b;
  logic signed [32:0]    part_c;
  logic signed [32:0]    part_s;
  logic signed [32:0]    sum_c;
  logic signed [32:0]    sum_s;
  logic [18:0]           rnd_y;
  logic                  out_free;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_valid_r;
  assign out_if.dir_x       = dir_x_r;
  assign out_if.dir_y       = dir_y_r;
  assign out_if.dir_z       = dir_z_r;
  assign out_if.yaw_angle   = yaw_o_r;
  assign out_if.pitch_angle = pitch_o_r;

  assign pitch_sum = 33'(pitch_acc_r) + 33'(py_r);
  assign u_step    = (u_r >= {1'b0, mod_r}) ? (u_r - {1'b0, mod_r}) : u_r;
  assign rot_a     = rot_step(ca_r, cnt_r);
  assign rot_b     = rot_step(cb_r, cnt_r);

  always_comb begin
    fold_a    = $signed({1'b0, yaw_acc_r});
    fold_flip = 1'b0;
    if (fold_a > ypdv_pkg::HALF_S) begin
      fold_a = fold_a - ypdv_pkg::FULL_S;
    end
    if (fold_a > ypdv_pkg::QUARTER_S) begin
      fold_a    = fold_a - ypdv_pkg::HALF_S;
      fold_flip = 1'b1;
    end else if (fold_a < -ypdv_pkg::QUARTER_S) begin
      fold_a    = fold_a + ypdv_pkg::HALF_S;
      fold_flip = 1'b1;
    end
  end

  // The sign bit of the multiplier carries negative weight, so the last step subtracts.
  assign part_c = !pc_r[0] ? 33'sd0 : (cnt_r == PROD_LAST) ? -33'(mc_r) : 33'(mc_r);
  assign part_s = !ps_r[0] ? 33'sd0 : (cnt_r == PROD_LAST) ? -33'(ms_r) : 33'(ms_r);
  assign sum_c  = $signed({pc_r[2*SW-1], pc_r[2*SW-1:SW]}) + part_c;
  assign sum_s  = $signed({ps_r[2*SW-1], ps_r[2*SW-1:SW]}) + part_s;

  assign rnd_y = {cb_r.y[31], cb_r.y[31:14]} + 19'd1;

  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sens_nxt      = sens_r;
    yaw_acc_nxt   = yaw_acc_r;
    pitch_acc_nxt = pitch_acc_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    sh_nxt        = sh_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    u_nxt         = u_r;
    mod_nxt       = mod_r;
    flip_nxt      = flip_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    mc_nxt        = mc_r;
    ms_nxt        = ms_r;
    pc_nxt        = pc_r;
    ps_nxt        = ps_r;
    out_valid_nxt = out_valid_r;
    dir_x_nxt     = dir_x_r;
    dir_y_nxt     = dir_y_r;
    dir_z_nxt     = dir_z_r;
    yaw_o_nxt     = yaw_o_r;
    pitch_o_nxt   = pitch_o_r;

    if (cfg_if.valid) begin
      sens_nxt = cfg_if.sensitivity;
    end
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          mx_nxt    = SW'(in_if.delta_x);
          my_nxt    = SW'(in_if.delta_y);
          sh_nxt    = sens_r;
          px_nxt    = '0;
          py_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sh_r[0]) begin
          px_nxt = px_r + mx_r;
          py_nxt = py_r + my_r;
        end
        mx_nxt  = mx_r <<< 1;
        my_nxt  = my_r <<< 1;
        sh_nxt  = sh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        u_nxt   = 33'(35'({1'b0, yaw_acc_r}) - 35'(px_r) + ypdv_pkg::WRAP_BIAS);
        mod_nxt = ypdv_pkg::MOD_TOP;
        if (pitch_sum > 33'(ypdv_pkg::PITCH_LIMIT)) begin
          pitch_acc_nxt = ypdv_pkg::PITCH_LIMIT;
        end else if (pitch_sum < -33'(ypdv_pkg::PITCH_LIMIT)) begin
          pitch_acc_nxt = -ypdv_pkg::PITCH_LIMIT;
        end else begin
          pitch_acc_nxt = pitch_sum[ypdv_pkg::PITCH_W-1:0];
        end
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        u_nxt   = u_step;
        mod_nxt = mod_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == WRAP_LAST) begin
          yaw_acc_nxt = u_step[ypdv_pkg::YAW_W-1:0];
          cnt_nxt     = '0;
          state_nxt   = ST_FOLD;
        end
      end
      ST_FOLD: begin
        flip_nxt  = fold_flip;
        ca_nxt.x  = ypdv_pkg::GAIN_Q30;
        ca_nxt.y  = '0;
        ca_nxt.z  = fold_a;
        cb_nxt.x  = ypdv_pkg::GAIN_Q30;
        cb_nxt.y  = '0;
        cb_nxt.z  = AW'(pitch_acc_r);
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        ca_nxt  = rot_a;
        cb_nxt  = rot_b;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ROT_LAST) begin
          mc_nxt    = flip_r ? -rot_a.x : rot_a.x;
          ms_nxt    = flip_r ? -rot_a.y : rot_a.y;
          pc_nxt    = {{SW{1'b0}}, rot_b.x};
          ps_nxt    = {{SW{1'b0}}, rot_b.x};
          cnt_nxt   = '0;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        if (cnt_r != PROD_LAST || out_free) begin
          pc_nxt = {sum_c, pc_r[SW-1:1]};
          ps_nxt = {sum_s, ps_r[SW-1:1]};
        end
        if (cnt_r != PROD_LAST) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (out_free) begin
          dir_x_nxt     = sat_q15(20'($signed({sum_c[32], sum_c[32:13]} + 21'd1) >>> 1));
          dir_z_nxt     = sat_q15(20'($signed({sum_s[32], sum_s[32:13]} + 21'd1) >>> 1));
          dir_y_nxt     = sat_q15(20'($signed(rnd_y[18:1])));
          yaw_o_nxt     = yaw_acc_r;
          pitch_o_nxt   = pitch_acc_r;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sens_r      <= ypdv_pkg::SENS_RESET;
      yaw_acc_r   <= ypdv_pkg::YAW_RESET;
      pitch_acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sens_r      <= sens_nxt;
      yaw_acc_r   <= yaw_acc_nxt;
      pitch_acc_r <= pitch_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    sh_r      <= sh_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    u_r       <= u_nxt;
    mod_r     <= mod_nxt;
    flip_r    <= flip_nxt;
    ca_r      <= ca_nxt;
    cb_r      <= cb_nxt;
    mc_r      <= mc_nxt;
    ms_r      <= ms_nxt;
    pc_r      <= pc_nxt;
    ps_r      <= ps_nxt;
    dir_x_r   <= dir_x_nxt;
    dir_y_r   <= dir_y_nxt;
    dir_z_r   <= dir_z_nxt;
    yaw_o_r   <= yaw_o_nxt;
    pitch_o_r <= pitch_o_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/ypdv_checker.sv
`default_nettype none
`include "yaw_pitch_direction_vector_top_macros.svh"

module ypdv_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input ypdv_pkg::dir_t   dir_x,
  input ypdv_pkg::dir_t   dir_y,
  input ypdv_pkg::dir_t   dir_z,
  input ypdv_pkg::yaw_t   yaw_angle,
  input ypdv_pkg::pitch_t pitch_angle
);

  logic        pitch_ok;
  logic [96:0] out_word;

  assign pitch_ok = (pitch_angle <= ypdv_pkg::PITCH_LIMIT) &&
                    (pitch_angle >= -ypdv_pkg::PITCH_LIMIT);
  assign out_word = {dir_x, dir_y, dir_z, yaw_angle, pitch_angle};

  `YPDV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `YPDV_ASSERT_SAME(a_yaw_wrapped, out_valid, yaw_angle < ypdv_pkg::FULL_TURN)
  `YPDV_ASSERT_SAME(a_pitch_clamped, out_valid, pitch_ok)
  `YPDV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind yaw_pitch_direction_vector_top ypdv_checker u_ypdv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .dir_x       (out_if.dir_x),
  .dir_y       (out_if.dir_y),
  .dir_z       (out_if.dir_z),
  .yaw_angle   (out_if.yaw_angle),
  .pitch_angle (out_if.pitch_angle)
);

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam longint TURN_Q16    = 64'sd23592960;
  localparam longint HALF_Q16    = 64'sd11796480;
  localparam longint QUARTER_Q16 = 64'sd5898240;
  localparam longint LIMIT_Q16   = 64'sd5832704;
  localparam int     STEPS       = ypdv_pkg::CORDIC_STEPS_DEF;
  localparam longint ATAN_Q16 [ypdv_pkg::TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum logic {ROW_MOVE, ROW_SENS} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    ypdv_pkg::delta_t   dx;
    ypdv_pkg::delta_t   dy;
    ypdv_pkg::sens_t    sens;
    bit                 known;
    ypdv_pkg::yaw_t     yaw;
    ypdv_pkg::pitch_t   pitch;
  } row_t;

  typedef struct {
    ypdv_pkg::dir_t   dir_x;
    ypdv_pkg::dir_t   dir_y;
    ypdv_pkg::dir_t   dir_z;
    ypdv_pkg::yaw_t   yaw_angle;
    ypdv_pkg::pitch_t pitch_angle;
  } view_t;

  logic clk;
  logic rst_n;

  ypdv_in_if  in_ch ();
  ypdv_cfg_if cfg_ch ();
  ypdv_out_if out_ch ();

  yaw_pitch_direction_vector_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .cfg_if (cfg_ch),
    .out_if (out_ch)
  );

  ypdv_pkg::sens_t sens_now   = ypdv_pkg::SENS_RESET;
  longint          view_yaw   = longint'(ypdv_pkg::YAW_RESET);
  longint          view_pitch = 0;

  view_t pending_views[$];
  row_t  script[$];

  bit quiet;
  int stall_left;
  int fails;
  int checked;
  int moves;
  int settings;
  int clamps;
  int wraps;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ypdv_pkg::delta_t pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ypdv_pkg::delta_t'($urandom_range(0, 32) - 16);
    if (r < 70) return ypdv_pkg::delta_t'($urandom_range(0, 1024) - 512);
    if (r < 88) return ypdv_pkg::delta_t'($urandom);
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic longint clip_q15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  // Rotation-mode CORDIC on an angle in degrees Q16 within plus or minus 90 degrees.
  function automatic void cordic_deg(input longint ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    x = 64'sh26DD3B6A;
    y = 0;
    z = ang;
    for (int i = 0; i < STEPS && i < ypdv_pkg::TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic view_t turn_view(input ypdv_pkg::delta_t dx, input ypdv_pkg::delta_t dy);
    longint raw_yaw, raw_pitch, a, cy, sy, cp, sp;
    bit     flip;
    view_t  v;
    raw_yaw = view_yaw - longint'(dx) * longint'(sens_now);
    view_yaw = raw_yaw % TURN_Q16;
    if (view_yaw < 0) view_yaw = view_yaw + TURN_Q16;
    if (view_yaw != raw_yaw) wraps++;
    raw_pitch = view_pitch + longint'(dy) * longint'(sens_now);
    view_pitch = raw_pitch;
    if (raw_pitch > LIMIT_Q16) view_pitch = LIMIT_Q16;
    if (raw_pitch < -LIMIT_Q16) view_pitch = -LIMIT_Q16;
    if (view_pitch != raw_pitch) clamps++;

    // The yaw is folded into the right half plane, with both signs flipped when folded.
    a = view_yaw;
    flip = 1'b0;
    if (a > HALF_Q16) a = a - TURN_Q16;
    if (a > QUARTER_Q16) begin
      a = a - HALF_Q16;
      flip = 1'b1;
    end else if (a < -QUARTER_Q16) begin
      a = a + HALF_Q16;
      flip = 1'b1;
    end
    cordic_deg(a, cy, sy);
    if (flip) begin
      cy = -cy;
      sy = -sy;
    end
    cordic_deg(view_pitch, cp, sp);

    v.dir_x = ypdv_pkg::dir_t'(clip_q15((cy * cp + (64'sd1 <<< 44)) >>> 45));
    v.dir_y = ypdv_pkg::dir_t'(clip_q15((sp + 64'sd16384) >>> 15));
    v.dir_z = ypdv_pkg::dir_t'(clip_q15((sy * cp + (64'sd1 <<< 44)) >>> 45));
    v.yaw_angle = ypdv_pkg::yaw_t'(view_yaw);
    v.pitch_angle = ypdv_pkg::pitch_t'(view_pitch);
    return v;
  endfunction

  function automatic bit field_ok(input string name, input longint want, input longint got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    view_t want;
    bit    ok;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_views.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, got yaw %0d pitch %0d",
                 $time, out_ch.yaw_angle, out_ch.pitch_angle);
        fails++;
      end else begin
        want = pending_views.pop_front();
        ok = field_ok("dir_x", want.dir_x, out_ch.dir_x)
           & field_ok("dir_y", want.dir_y, out_ch.dir_y)
           & field_ok("dir_z", want.dir_z, out_ch.dir_z)
           & field_ok("yaw_angle", want.yaw_angle, out_ch.yaw_angle)
           & field_ok("pitch_angle", want.pitch_angle, out_ch.pitch_angle);
        if (!ok) fails++;
        checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic put_row(input row_kind_t kind, input ypdv_pkg::delta_t dx,
                         input ypdv_pkg::delta_t dy, input ypdv_pkg::sens_t sens,
                         input bit known, input ypdv_pkg::yaw_t yaw,
                         input ypdv_pkg::pitch_t pitch);
    row_t r;
    r.kind = kind;
    r.dx = dx;
    r.dy = dy;
    r.sens = sens;
    r.known = known;
    r.yaw = yaw;
    r.pitch = pitch;
    script.push_back(r);
  endtask

  task automatic send_move(input ypdv_pkg::delta_t dx, input ypdv_pkg::delta_t dy,
                           input bit known, input ypdv_pkg::yaw_t want_yaw,
                           input ypdv_pkg::pitch_t want_pitch);
    int    gap;
    view_t v;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.delta_x <= dx;
    in_ch.delta_y <= dy;
    do @(posedge clk); while (!in_ch.ready);
    v = turn_view(dx, dy);
    if (known) begin
      v.yaw_angle = want_yaw;
      v.pitch_angle = want_pitch;
    end
    pending_views.push_back(v);
    moves++;
    @(negedge clk);
  endtask

  task automatic drain_views();
    in_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
  endtask

  task automatic write_sens(input ypdv_pkg::sens_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.sensitivity <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sens_now = value;
    settings++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    ypdv_pkg::sens_t sens;
    int              count;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.delta_x = '0;
    in_ch.delta_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.sensitivity = '0;
    out_ch.ready = 1'b0;
    quiet = 1'b0;
    stall_left = 0;

    put_row(ROW_MOVE, 0, 0, 0, 1, 17694720, 0);
    put_row(ROW_MOVE, 0, 32767, 0, 1, 17694720, 5832704);
    put_row(ROW_MOVE, 0, -32768, 0, 1, 17694720, -5832704);
    put_row(ROW_SENS, 0, 0, 32768, 0, 0, 0);
    put_row(ROW_MOVE, -180, 178, 0, 1, 0, 0);
    put_row(ROW_MOVE, -180, 178, 0, 1, 5898240, 5832704);
    put_row(ROW_MOVE, -180, 1, 0, 1, 11796480, 5832704);
    put_row(ROW_MOVE, -180, -356, 0, 1, 17694720, -5832704);
    put_row(ROW_MOVE, 180, -1, 0, 1, 11796480, -5832704);
    put_row(ROW_MOVE, 360, 178, 0, 1, 0, 0);
    put_row(ROW_MOVE, 1, 0, 0, 1, 23560192, 0);
    put_row(ROW_SENS, 0, 0, 65535, 0, 0, 0);
    put_row(ROW_MOVE, 32767, 32767, 0, 0, 0, 0);
    put_row(ROW_MOVE, -32768, -32768, 0, 0, 0, 0);
    put_row(ROW_MOVE, 16'sh5555, -21846, 0, 0, 0, 0);
    put_row(ROW_MOVE, -21846, 16'sh5555, 0, 0, 0, 0);
    put_row(ROW_SENS, 0, 0, 0, 0, 0, 0);
    put_row(ROW_MOVE, 32767, -32768, 0, 0, 0, 0);
    put_row(ROW_SENS, 0, 0, 6554, 0, 0, 0);
    put_row(ROW_MOVE, -1, 1, 0, 0, 0, 0);
    put_row(ROW_MOVE, 1, -1, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_SENS) begin
        drain_views();
        write_sens(script[i].sens);
      end else begin
        send_move(script[i].dx, script[i].dy, script[i].known, script[i].yaw,
                  script[i].pitch);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: sens = 16'd65535;
        1: sens = 16'd1;
        2: sens = 16'd0;
        3: sens = ypdv_pkg::sens_t'($urandom_range(0, 65535));
        4: sens = ypdv_pkg::sens_t'($urandom_range(1, 8192));
        5: sens = ypdv_pkg::SENS_RESET;
        default: sens = ypdv_pkg::sens_t'($urandom_range(32768, 65535));
      endcase
      count = (ph == 2) ? 40 : 140;
      quiet = (ph % 3 == 0);
      drain_views();
      write_sens(sens);
      for (int n = 0; n < count; n++) begin
        if (n == count / 2) drain_views();
        send_move(pick_delta(), pick_delta(), 1'b0, '0, '0);
      end
    end

    drain_views();
    repeat (100) @(posedge clk);
    $display("Checked %0d results from %0d movements over %0d sensitivity settings.",
             checked, moves, settings);
    $display("Pitch reached its limit %0d times and yaw wrapped around %0d times.",
             clamps, wraps);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/ypdv_pkg.sv
hdl/ypdv_ifs.sv
hdl/yaw_pitch_direction_vector_top.sv
hdl/ypdv_checker.sv
sim/tb_top.sv
